### rtl/rgb565_bilinear_line_scaler_core_defines.svh
// ----------------------------------------------------------------------------
// RGB565 line scaler assertion macros
// Shared assertion wrappers clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef RGB565_BILINEAR_LINE_SCALER_CORE_DEFINES_SVH
`define RGB565_BILINEAR_LINE_SCALER_CORE_DEFINES_SVH

// Plain property, checked outside reset.
`define RBLSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rblsc assertion failed");

// Overlapping implication, checked outside reset.
`define RBLSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rblsc implication failed");

// Next-cycle implication, checked outside reset.
`define RBLSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rblsc next-cycle check failed");

`endif

### rtl/rblsc_pkg.sv
// ----------------------------------------------------------------------------
// rblsc_pkg
// Constants shared by the RGB565 bilinear line scaler modules.
// ----------------------------------------------------------------------------
package rblsc_pkg;

    localparam int PIX_W    = 16;
    localparam int WGT_W    = 6;
    localparam int POS_W    = 26;
    localparam int STEP_W   = 27;
    localparam int LEN_W    = 11;
    localparam int COL_W    = 10;
    localparam int OP_W     = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 16;

    localparam logic [PIX_W-1:0] RB_MASK    = 16'hf81f;
    localparam logic [PIX_W-1:0] G_MASK     = 16'h07e0;
    localparam logic [WGT_W:0]   WEIGHT_ONE = 7'h40;

    // item kinds carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT  = 2'd2;

    // configuration register indexes
    localparam logic CFG_X_STEP     = 1'b0;
    localparam logic CFG_ROW_LENGTH = 1'b1;

    localparam logic [STEP_W-1:0] X_STEP_RESET     = 27'd65536;
    localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = 11'd1024;

endpackage

### rtl/rblsc_mix565.sv
// ----------------------------------------------------------------------------
// rblsc_mix565
// Blends two RGB565 pixels with a 6-bit weight on the packed R/B and G masks.
// ----------------------------------------------------------------------------
module rblsc_mix565
(
    input  logic [rblsc_pkg::PIX_W-1:0] a,
    input  logic [rblsc_pkg::PIX_W-1:0] b,
    input  logic [rblsc_pkg::WGT_W-1:0] w,
    output logic [rblsc_pkg::PIX_W-1:0] y
);

    logic [rblsc_pkg::WGT_W:0] inv;
    logic [23:0]               rb_sum;
    logic [23:0]               g_sum;

    assign inv = rblsc_pkg::WEIGHT_ONE - {1'b0, w};

    // R and B sit 6 bits apart in the mask, so one product carries both
    assign rb_sum = ({8'd0, a & rblsc_pkg::RB_MASK} * {17'd0, inv})
                  + ({8'd0, b & rblsc_pkg::RB_MASK} * {18'd0, w});
    assign g_sum  = ({8'd0, a & rblsc_pkg::G_MASK} * {17'd0, inv})
                  + ({8'd0, b & rblsc_pkg::G_MASK} * {18'd0, w});

    assign y = (rb_sum[21:6] & rblsc_pkg::RB_MASK) | (g_sum[21:6] & rblsc_pkg::G_MASK);

endmodule

### rtl/rgb565_bilinear_line_scaler_core.sv
// ----------------------------------------------------------------------------
// rgb565_bilinear_line_scaler_core
// Bilinear RGB565 row scaler with an upper/lower line store.
// ----------------------------------------------------------------------------
// Load and start transfers leave the core idle. An emit transfer moves the core
// through ST_VERT and ST_HORZ: the line store is read at both neighbor columns
// on the accepting edge, the vertical blend is registered in the next cycle and
// the horizontal blend enters the output register in ST_HORZ once that is free,
// which frees the core for the next item while the pixel waits on m_tready. The
// line store is one synchronous memory of LINE_WIDTH entries holding the
// upper and lower pixel side by side, read at two addresses per cycle; its
// contents are undefined until loaded and need no clearing after reset.
// Configuration writes are always accepted and must only be issued while the
// core is idle.
`include "rgb565_bilinear_line_scaler_core_defines.svh"

module rgb565_bilinear_line_scaler_core
#(
    parameter int LINE_WIDTH = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    // tdata: column_index[9:0], top_pixel[25:10], bottom_pixel[41:26],
    //        start_x[67:42], row_fraction[83:68], single_row[84], zero fill
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rblsc_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: opcode[1:0]
    input  logic [rblsc_pkg::OP_W-1:0]       s_tuser,

    // tdata: pixel[15:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rblsc_pkg::M_DATA_W-1:0]   m_tdata,
    // tlast: row_end
    output logic                             m_tlast,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [rblsc_pkg::STEP_W-1:0]     cfg_data
);

    localparam int AW     = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int CMP_W  = 14;
    localparam logic [CMP_W-1:0] LAST_COL = CMP_W'(LINE_WIDTH - 1);
    localparam logic [CMP_W-1:0] DEPTH    = CMP_W'(LINE_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_VERT = 2'd1;
    localparam logic [1:0] ST_HORZ = 2'd2;

    // input field split
    logic [rblsc_pkg::COL_W-1:0] column_index;
    logic [rblsc_pkg::PIX_W-1:0] top_pixel;
    logic [rblsc_pkg::PIX_W-1:0] bottom_pixel;
    logic [rblsc_pkg::POS_W-1:0] start_x;
    logic [rblsc_pkg::PIX_W-1:0] row_fraction;
    logic                        single_row;

    assign column_index = s_tdata[9:0];
    assign top_pixel    = s_tdata[25:10];
    assign bottom_pixel = s_tdata[41:26];
    assign start_x      = s_tdata[67:42];
    assign row_fraction = s_tdata[83:68];
    assign single_row   = s_tdata[84];

    logic [1:0]                    state_reg, state_next;
    logic [rblsc_pkg::STEP_W-1:0]  x_step_reg;
    logic [rblsc_pkg::LEN_W-1:0]   row_length_reg;
    logic [rblsc_pkg::POS_W-1:0]   x_position_reg;
    logic [rblsc_pkg::WGT_W-1:0]   vertical_weight_reg;
    logic                          one_row_mode_reg;
    logic [rblsc_pkg::LEN_W-1:0]   emitted_count_reg;

    logic [rblsc_pkg::WGT_W-1:0]   wx_reg;
    logic                          row_end_reg;
    logic [31:0]                   rd0_reg;
    logic [31:0]                   rd1_reg;
    logic [rblsc_pkg::PIX_W-1:0]   a_reg, a_next;
    logic [rblsc_pkg::PIX_W-1:0]   b_reg, b_next;
    logic                          out_valid_reg;
    logic [rblsc_pkg::PIX_W-1:0]   out_pixel_reg;
    logic                          out_last_reg;

    logic [31:0] line_mem [LINE_WIDTH];

    logic                        in_xfer;
    logic                        do_load;
    logic                        do_start;
    logic                        do_emit;
    logic [CMP_W-1:0]            col0_ext;
    logic [CMP_W-1:0]            col1_ext;
    logic [AW-1:0]               addr0;
    logic [AW-1:0]               addr1;
    logic [CMP_W-1:0]            load_ext;
    logic [AW-1:0]               load_addr;
    logic [rblsc_pkg::LEN_W:0]   count_inc;
    logic                        row_end_now;
    logic [rblsc_pkg::PIX_W-1:0] vmix0;
    logic [rblsc_pkg::PIX_W-1:0] vmix1;
    logic [rblsc_pkg::PIX_W-1:0] hmix;
    logic                        out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign do_load  = in_xfer && (s_tuser == rblsc_pkg::OP_LOAD);
    assign do_start = in_xfer && (s_tuser == rblsc_pkg::OP_START);
    assign do_emit  = in_xfer && (s_tuser == rblsc_pkg::OP_EMIT);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // neighbor columns, saturated to the last stored column
    assign col0_ext = CMP_W'(x_position_reg[rblsc_pkg::POS_W-1:16]);
    assign col1_ext = col0_ext + CMP_W'(1);
    assign addr0    = (col0_ext > LAST_COL) ? AW'(LAST_COL) : AW'(col0_ext);
    assign addr1    = (col1_ext > LAST_COL) ? AW'(LAST_COL) : AW'(col1_ext);

    assign load_ext  = CMP_W'(column_index);
    assign load_addr = AW'(load_ext);

    assign count_inc   = {1'b0, emitted_count_reg} + (rblsc_pkg::LEN_W+1)'(1);
    assign row_end_now = (count_inc >= {1'b0, row_length_reg});

    always_ff @(posedge clk)
    begin
        if (do_load && (load_ext < DEPTH))
        begin
            line_mem[load_addr] <= {top_pixel, bottom_pixel};
        end
        if (do_emit)
        begin
            rd0_reg <= line_mem[addr0];
            rd1_reg <= line_mem[addr1];
        end
    end

    rblsc_mix565 u_vmix0
    (
        .a (rd0_reg[31:16]),
        .b (rd0_reg[15:0]),
        .w (vertical_weight_reg),
        .y (vmix0)
    );

    rblsc_mix565 u_vmix1
    (
        .a (rd1_reg[31:16]),
        .b (rd1_reg[15:0]),
        .w (vertical_weight_reg),
        .y (vmix1)
    );

    rblsc_mix565 u_hmix
    (
        .a (a_reg),
        .b (b_reg),
        .w (wx_reg),
        .y (hmix)
    );

    assign a_next   = one_row_mode_reg ? rd0_reg[31:16] : vmix0;
    assign b_next   = one_row_mode_reg ? rd1_reg[31:16] : vmix1;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_emit)
                begin
                    state_next = ST_VERT;
                end
            end
            ST_VERT:
            begin
                state_next = ST_HORZ;
            end
            ST_HORZ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            x_step_reg          <= rblsc_pkg::X_STEP_RESET;
            row_length_reg      <= rblsc_pkg::ROW_LENGTH_RESET;
            x_position_reg      <= '0;
            vertical_weight_reg <= '0;
            one_row_mode_reg    <= 1'b0;
            emitted_count_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rblsc_pkg::CFG_X_STEP:     x_step_reg     <= cfg_data;
                    rblsc_pkg::CFG_ROW_LENGTH: row_length_reg <= cfg_data[rblsc_pkg::LEN_W-1:0];
                    default:                   ;
                endcase
            end

            if (do_start)
            begin
                x_position_reg      <= start_x;
                vertical_weight_reg <= row_fraction[15:10];
                one_row_mode_reg    <= single_row;
                emitted_count_reg   <= '0;
            end
            else if (do_emit)
            begin
                // step is truncated to its low 26 bits, giving the modulo-2^26 sum
                x_position_reg    <= x_position_reg + x_step_reg[rblsc_pkg::POS_W-1:0];
                emitted_count_reg <= row_end_now ? '0 : count_inc[rblsc_pkg::LEN_W-1:0];
            end

            if ((state_reg == ST_HORZ) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            wx_reg      <= x_position_reg[15:10];
            row_end_reg <= row_end_now;
        end
        if (state_reg == ST_VERT)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if ((state_reg == ST_HORZ) && out_free)
        begin
            out_pixel_reg <= (wx_reg != '0) ? hmix : a_reg;
            out_last_reg  <= row_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

    `RBLSC_ASSERT_NEXT(a_emit_enters_vert, do_emit, state_reg == ST_VERT)
    `RBLSC_ASSERT_NEXT(a_nonemit_stays_idle, in_xfer && !do_emit, state_reg == ST_IDLE)
    `RBLSC_ASSERT_NEXT(a_horz_holds_on_stall, (state_reg == ST_HORZ) && m_tvalid && !m_tready,
                       (state_reg == ST_HORZ) && m_tvalid)
    `RBLSC_ASSERT_IMPL(a_result_from_horz, $rose(m_tvalid), $past(state_reg == ST_HORZ))

endmodule
